// ----- hdl/srgb_to_gray_luminance_unit_macros.svh -----
// Assertion macros used by the encode search stage of the sRGB to gray luminance unit.
`ifndef SRGB_TO_GRAY_LUMINANCE_UNIT_MACROS_SVH
`define SRGB_TO_GRAY_LUMINANCE_UNIT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define SGL_ASSERT_NOW(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define SGL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/sgl_pkg.sv -----
// Constants and elaboration-time table builders for the sRGB to gray unit.
package sgl_pkg;

	typedef logic [63:0] u64_t;

	localparam logic [15:0] W_R = 16'd13933;
	localparam logic [15:0] W_G = 16'd46871;
	localparam logic [15:0] W_B = 16'd4732;

	localparam u64_t Q30_ONE = 64'd1 << 30;

	// Restoring long division, used only while building tables.
	function automatic u64_t long_div(u64_t n, u64_t d);
		u64_t q;
		u64_t r;
		q = '0;
		r = '0;
		for (int k = 63; k >= 0; k--) begin
			r = {r[62:0], n[k]};
			if (r >= d) begin
				r = r - d;
				q[k] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic u64_t mul_q30(u64_t a, u64_t b);
		u64_t p;
		p = a * b;
		return p >> 30;
	endfunction

	function automatic u64_t pow5_q30(u64_t r);
		u64_t p;
		p = r;
		for (int k = 0; k < 4; k++) begin
			p = mul_q30(p, r);
		end
		return p;
	endfunction

	function automatic u64_t pow3_q30(u64_t r);
		return mul_q30(mul_q30(r, r), r);
	endfunction

	// Largest Q30 value in [0, 1.0] whose truncated cube or fifth power is <= q.
	function automatic u64_t root_q30(u64_t q, logic fifth);
		u64_t lo;
		u64_t hi;
		u64_t mid;
		u64_t f;
		lo = '0;
		hi = Q30_ONE;
		while (lo < hi) begin
			mid = (lo + hi + 64'd1) >> 1;
			f = fifth ? pow5_q30(mid) : pow3_q30(mid);
			if (f <= q) begin
				lo = mid;
			end else begin
				hi = mid - 64'd1;
			end
		end
		return lo;
	endfunction

	function automatic u64_t isqrt64(u64_t v_in);
		u64_t v;
		u64_t r;
		u64_t b;
		v = v_in;
		r = '0;
		b = 64'd1 << 62;
		while (b > v) begin
			b = b >> 2;
		end
		while (b != 64'd0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Linear value of one channel code, Q1.lb with 1.0 exact.
	function automatic u64_t lin_entry(int c, int cb, int lb);
		u64_t m;
		u64_t cc;
		u64_t den;
		u64_t val;
		u64_t t;
		u64_t s;
		u64_t r;
		u64_t y;
		m = (64'd1 << cb) - 64'd1;
		cc = u64_t'(c);
		if (cc * 64'd100000 < 64'd4045 * m) begin
			den = m * 64'd1292;
			val = long_div((((cc * 64'd100) << lb) * 64'd2) + den, 64'd2 * den);
		end else begin
			t = long_div((cc * 64'd1000 + 64'd55 * m) << 30, 64'd1055 * m);
			s = mul_q30(t, t);
			r = root_q30(s, 1'b1);
			y = mul_q30(s, r);
			val = ((y << lb) + (Q30_ONE >> 1)) >> 30;
		end
		if (val > (64'd1 << lb)) begin
			val = 64'd1 << lb;
		end
		return val;
	endfunction

	// Gray code for luminance bin i of 2^eib bins.
	function automatic u64_t enc_entry(u64_t i, int cb, int eib);
		u64_t m;
		u64_t odd;
		u64_t code;
		u64_t den;
		u64_t y;
		u64_t s;
		u64_t q4;
		u64_t c6;
		u64_t p;
		u64_t num;
		u64_t off;
		u64_t g;
		m = (64'd1 << cb) - 64'd1;
		odd = 64'd2 * i + 64'd1;
		if (odd * 64'd10000000 <= 64'd31308 * (64'd1 << (eib + 1))) begin
			den = 64'd100 * (64'd1 << (eib + 1));
			code = long_div(64'd2 * odd * 64'd1292 * m + den, 64'd2 * den);
		end else begin
			y = odd << (30 - eib - 1);
			s = isqrt64(y << 30);
			q4 = isqrt64(s << 30);
			c6 = root_q30(s, 1'b0);
			p = mul_q30(q4, c6);
			num = 64'd1055 * p;
			off = 64'd55 * Q30_ONE;
			g = (num > off) ? (num - off) : 64'd0;
			code = long_div(64'd2 * g * m + 64'd1000 * Q30_ONE, 64'd2000 * Q30_ONE);
		end
		if (code > m) begin
			code = m;
		end
		return code;
	endfunction

	// First luminance bin whose gray code reaches k; 2^eib when none does.
	function automatic u64_t thr_entry(int k, int cb, int eib);
		u64_t lo;
		u64_t hi;
		u64_t mid;
		lo = '0;
		hi = 64'd1 << eib;
		if (k == 0) begin
			return 64'd0;
		end
		while (lo < hi) begin
			mid = (lo + hi) >> 1;
			if (enc_entry(mid, cb, eib) >= u64_t'(k)) begin
				hi = mid;
			end else begin
				lo = mid + 64'd1;
			end
		end
		return lo;
	endfunction

endpackage

// ----- hdl/sgl_linearize.sv -----
// Stage 1: per-channel sRGB to linear table lookup.
module sgl_linearize #(
	parameter int CHANNEL_BITS = 8,
	parameter int LINEAR_BITS  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_in,
	input  logic [CHANNEL_BITS-1:0] red_code,
	input  logic [CHANNEL_BITS-1:0] green_code,
	input  logic [CHANNEL_BITS-1:0] blue_code,
	output logic                    vld_s1,
	output logic [LINEAR_BITS:0]    lin_r_s1,
	output logic [LINEAR_BITS:0]    lin_g_s1,
	output logic [LINEAR_BITS:0]    lin_b_s1
);

	localparam int LW      = LINEAR_BITS + 1;
	localparam int ENTRIES = 1 << CHANNEL_BITS;

	logic [LW-1:0] lin_tab [ENTRIES];

	for (genvar i = 0; i < ENTRIES; i++) begin : g_lin
		localparam logic [LW-1:0] VAL = LW'(sgl_pkg::lin_entry(i, CHANNEL_BITS, LINEAR_BITS));
		assign lin_tab[i] = VAL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lin_r_s1 <= lin_tab[red_code];
			lin_g_s1 <= lin_tab[green_code];
			lin_b_s1 <= lin_tab[blue_code];
		end
	end

endmodule

// ----- hdl/sgl_luma_mix.sv -----
// Stages 2 and 3: Rec.709 weighting, sum and encode index with saturation.
module sgl_luma_mix #(
	parameter int LINEAR_BITS       = 16,
	parameter int ENCODE_INDEX_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vld_in,
	input  logic [LINEAR_BITS:0]         lin_r,
	input  logic [LINEAR_BITS:0]         lin_g,
	input  logic [LINEAR_BITS:0]         lin_b,
	output logic                         vld_s3,
	output logic [ENCODE_INDEX_BITS-1:0] idx_s3
);

	localparam int LW = LINEAR_BITS + 1;
	localparam int PW = LW + 16;
	localparam int SW = PW + 2;
	localparam int SH = LINEAR_BITS + 16 - ENCODE_INDEX_BITS;
	localparam int FW = SW - SH;
	localparam logic [FW-1:0] IDX_MAX = FW'((1 << ENCODE_INDEX_BITS) - 1);

	logic          vld_s2;
	logic [PW-1:0] prod_r_s2;
	logic [PW-1:0] prod_g_s2;
	logic [PW-1:0] prod_b_s2;
	logic [SW-1:0] sum;
	logic [FW-1:0] idx_full;

	assign sum = SW'(prod_r_s2) + SW'(prod_g_s2) + SW'(prod_b_s2);
	assign idx_full = sum[SW-1:SH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_in;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_r_s2 <= PW'(lin_r) * PW'(sgl_pkg::W_R);
			prod_g_s2 <= PW'(lin_g) * PW'(sgl_pkg::W_G);
			prod_b_s2 <= PW'(lin_b) * PW'(sgl_pkg::W_B);
			// clamp pure white into the last bin
			if (idx_full > IDX_MAX) begin
				idx_s3 <= IDX_MAX[ENCODE_INDEX_BITS-1:0];
			end else begin
				idx_s3 <= idx_full[ENCODE_INDEX_BITS-1:0];
			end
		end
	end

endmodule

// ----- hdl/sgl_encode_search.sv -----
// Stages 4 on: gray code found one bit per stage by search over bin thresholds.
`include "srgb_to_gray_luminance_unit_macros.svh"

module sgl_encode_search #(
	parameter int CHANNEL_BITS      = 8,
	parameter int ENCODE_INDEX_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vld_in,
	input  logic [ENCODE_INDEX_BITS-1:0] idx,
	output logic                         vld_out,
	output logic [CHANNEL_BITS-1:0]      gray_out
);

	localparam int CB      = CHANNEL_BITS;
	localparam int EIB     = ENCODE_INDEX_BITS;
	localparam int TW      = EIB + 1;
	localparam int ENTRIES = 1 << CB;
	localparam logic [CB-1:0] CODE_MAX = {CB{1'b1}};

	// thr_tab[k]: first luminance bin whose gray code is k or above
	logic [TW-1:0]  thr_tab [ENTRIES];
	logic           vld_s   [CB];
	logic [CB-1:0]  acc_s   [CB];
	logic [EIB-1:0] idx_s   [CB];

	for (genvar k = 0; k < ENTRIES; k++) begin : g_thr
		localparam logic [TW-1:0] VAL = TW'(sgl_pkg::thr_entry(k, CB, EIB));
		assign thr_tab[k] = VAL;
	end

	for (genvar j = 0; j < CB; j++) begin : g_stage
		logic           vld_prev;
		logic [CB-1:0]  acc_prev;
		logic [EIB-1:0] idx_prev;
		logic [CB-1:0]  cand;

		if (j == 0) begin : g_first
			assign vld_prev = vld_in;
			assign acc_prev = '0;
			assign idx_prev = idx;
		end else begin : g_next
			assign vld_prev = vld_s[j-1];
			assign acc_prev = acc_s[j-1];
			assign idx_prev = idx_s[j-1];
		end

		// try setting this stage's bit of the gray code
		assign cand = acc_prev | (CB'(1) << (CB - 1 - j));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				idx_s[j] <= idx_prev;
				acc_s[j] <= (TW'(idx_prev) >= thr_tab[cand]) ? cand : acc_prev;
			end
		end
	end

	assign vld_out  = vld_s[CB-1];
	assign gray_out = acc_s[CB-1];

	`SGL_ASSERT_NOW(a_gray_low_bound, clk, arst_n,
		!vld_out || (thr_tab[gray_out] <= TW'(idx_s[CB-1])),
		"gray code above its luminance bin")
	`SGL_ASSERT_NOW(a_gray_high_bound, clk, arst_n,
		!vld_out || (gray_out == CODE_MAX) ||
		(thr_tab[gray_out + CB'(1)] > TW'(idx_s[CB-1])),
		"gray code below its luminance bin")
	`SGL_ASSERT_NEXT(a_stall_holds, clk, arst_n, !en,
		$stable(vld_out) && $stable(gray_out),
		"search pipeline moved during a stall")
	`SGL_ASSERT_NEXT(a_valid_advances, clk, arst_n, en && vld_s[CB-2],
		vld_out, "valid bit lost in the last search stage")

endmodule

// ----- hdl/srgb_to_gray_luminance_unit.sv -----
// Top level of the sRGB to gray luminance unit.
//
// Usage:
//   Input channel: in_valid / in_ready carry one pixel per beat as sRGB codes
//   red_code, green_code and blue_code. Output channel: out_valid / out_ready
//   carry one gray_code per beat, the sRGB code of the Rec.709 luminance.
//   Every input beat gives exactly one output beat, in order.
// Pipeline: from input beat to out_valid, registered stages of channel
//   linearization lookup, weight multiply, and sum and bin index, then one
//   search stage per output bit.
// Throughput: one pixel per clock while out_ready stays high.
// Reset: arst_n clears all stage valid bits; the block accepts a beat straight
//   after reset. The tables are constants fixed at elaboration.
// Stall: with out_valid high and out_ready low the whole pipeline holds and
//   in_ready drops in the same cycle; nothing is dropped or repeated. Empty
//   stages behind a stall are not squeezed out.
module srgb_to_gray_luminance_unit #(
	parameter int CHANNEL_BITS      = 8,
	parameter int LINEAR_BITS       = 16,
	parameter int ENCODE_INDEX_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [CHANNEL_BITS-1:0] red_code,
	input  logic [CHANNEL_BITS-1:0] green_code,
	input  logic [CHANNEL_BITS-1:0] blue_code,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [CHANNEL_BITS-1:0] gray_code
);

	logic                         en;
	logic                         lin_vld;
	logic [LINEAR_BITS:0]         lin_r;
	logic [LINEAR_BITS:0]         lin_g;
	logic [LINEAR_BITS:0]         lin_b;
	logic                         mix_vld;
	logic [ENCODE_INDEX_BITS-1:0] mix_idx;

	// advance everything unless a finished beat is waiting on the receiver
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	sgl_linearize #(
		.CHANNEL_BITS (CHANNEL_BITS),
		.LINEAR_BITS  (LINEAR_BITS)
	) u_linearize (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vld_in     (in_valid),
		.red_code   (red_code),
		.green_code (green_code),
		.blue_code  (blue_code),
		.vld_s1     (lin_vld),
		.lin_r_s1   (lin_r),
		.lin_g_s1   (lin_g),
		.lin_b_s1   (lin_b)
	);

	sgl_luma_mix #(
		.LINEAR_BITS       (LINEAR_BITS),
		.ENCODE_INDEX_BITS (ENCODE_INDEX_BITS)
	) u_luma_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_in (lin_vld),
		.lin_r  (lin_r),
		.lin_g  (lin_g),
		.lin_b  (lin_b),
		.vld_s3 (mix_vld),
		.idx_s3 (mix_idx)
	);

	sgl_encode_search #(
		.CHANNEL_BITS      (CHANNEL_BITS),
		.ENCODE_INDEX_BITS (ENCODE_INDEX_BITS)
	) u_encode_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (mix_vld),
		.idx      (mix_idx),
		.vld_out  (out_valid),
		.gray_out (gray_code)
	);

endmodule

// ----- tb/srgb_gray_checker.sv -----
// Checker for the sRGB to gray unit: watches both channels, predicts gray codes, compares.
module srgb_gray_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] red_code,
	input  logic [7:0] green_code,
	input  logic [7:0] blue_code,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] gray_code,
	output int         fail_count,
	output int         pending
);

	typedef bit [63:0] word_t;

	localparam int    CH_BITS   = 8;
	localparam int    LIN_BITS  = 16;
	localparam int    IDX_BITS  = 12;
	localparam word_t CODE_MAX  = (64'd1 << CH_BITS) - 64'd1;
	localparam word_t ONE_Q30   = 64'd1 << 30;
	localparam word_t BIN_LAST  = (64'd1 << IDX_BITS) - 64'd1;
	localparam word_t WEIGHT_R  = 64'd13933;
	localparam word_t WEIGHT_G  = 64'd46871;
	localparam word_t WEIGHT_B  = 64'd4732;

	logic [LIN_BITS:0]  linear_lut [0:(1 << CH_BITS) - 1];
	logic [CH_BITS-1:0] gamma_lut  [0:(1 << IDX_BITS) - 1];
	logic [CH_BITS-1:0] gray_due   [$];

	function automatic word_t q30_mul(word_t a, word_t b);
		return (a * b) >> 30;
	endfunction

	// Largest Q30 value up to 1.0 whose truncated fifth power (or cube) stays <= q.
	function automatic word_t q30_root(word_t q, bit fifth);
		word_t lo;
		word_t hi;
		word_t mid;
		word_t p;
		lo = 64'd0;
		hi = ONE_Q30;
		while (lo < hi) begin
			mid = (lo + hi + 64'd1) >> 1;
			if (fifth) begin
				p = mid;
				repeat (4) p = q30_mul(p, mid);
			end else begin
				p = q30_mul(q30_mul(mid, mid), mid);
			end
			if (p <= q) begin
				lo = mid;
			end else begin
				hi = mid - 64'd1;
			end
		end
		return lo;
	endfunction

	function automatic word_t int_sqrt(word_t v_in);
		word_t v;
		word_t r;
		word_t b;
		v = v_in;
		r = 64'd0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 64'd0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic word_t channel_to_linear(word_t c);
		word_t den;
		word_t t;
		word_t s;
		word_t y;
		word_t val;
		if (c * 64'd100000 < 64'd4045 * CODE_MAX) begin
			den = CODE_MAX * 64'd1292;
			val = ((((c * 64'd100) << LIN_BITS) * 64'd2) + den) / (64'd2 * den);
		end else begin
			t = ((c * 64'd1000 + 64'd55 * CODE_MAX) << 30) / (64'd1055 * CODE_MAX);
			s = q30_mul(t, t);
			y = q30_mul(s, q30_root(s, 1'b1));
			val = ((y << LIN_BITS) + (ONE_Q30 >> 1)) >> 30;
		end
		if (val > (64'd1 << LIN_BITS))
			val = 64'd1 << LIN_BITS;
		return val;
	endfunction

	// Gray code at the midpoint of luminance bin i.
	function automatic word_t bin_to_gray(word_t i);
		word_t odd;
		word_t den;
		word_t code;
		word_t s;
		word_t p;
		word_t num;
		word_t g;
		odd = 64'd2 * i + 64'd1;
		if (odd * 64'd10000000 <= 64'd31308 * (64'd1 << (IDX_BITS + 1))) begin
			den = 64'd100 * (64'd1 << (IDX_BITS + 1));
			code = (64'd2 * odd * 64'd1292 * CODE_MAX + den) / (64'd2 * den);
		end else begin
			s = int_sqrt((odd << (30 - IDX_BITS - 1)) << 30);
			p = q30_mul(int_sqrt(s << 30), q30_root(s, 1'b0));
			num = 64'd1055 * p;
			g = (num > 64'd55 * ONE_Q30) ? (num - 64'd55 * ONE_Q30) : 64'd0;
			code = (64'd2 * g * CODE_MAX + 64'd1000 * ONE_Q30) / (64'd2000 * ONE_Q30);
		end
		if (code > CODE_MAX)
			code = CODE_MAX;
		return code;
	endfunction

	function automatic logic [7:0] gray_of_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		word_t luma;
		word_t bin;
		luma = WEIGHT_R * word_t'(linear_lut[r]) + WEIGHT_G * word_t'(linear_lut[g])
			+ WEIGHT_B * word_t'(linear_lut[b]);
		bin = luma >> (LIN_BITS + 16 - IDX_BITS);
		// pure white lands one past the last bin
		if (bin > BIN_LAST)
			bin = BIN_LAST;
		return gamma_lut[bin[IDX_BITS-1:0]];
	endfunction

	initial begin
		word_t lin;
		word_t code;
		fail_count = 0;
		pending = 0;
		for (int k = 0; k < (1 << CH_BITS); k++) begin
			lin = channel_to_linear(word_t'(k));
			linear_lut[k] = lin[LIN_BITS:0];
		end
		for (int k = 0; k < (1 << IDX_BITS); k++) begin
			code = bin_to_gray(word_t'(k));
			gamma_lut[k] = code[CH_BITS-1:0];
		end
	end

	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n) begin
			// retire the output beat before queueing the input beat of the same edge
			if (out_valid && out_ready) begin
				if (gray_due.size() == 0) begin
					$error("gray_code: expected no beat, actual %0d", gray_code);
					fail_count <= fail_count + 1;
				end else begin
					want = gray_due.pop_front();
					if (gray_code !== want) begin
						$error("gray_code: expected %0d, actual %0d", want, gray_code);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready)
				gray_due.push_back(gray_of_pixel(red_code, green_code, blue_code));
			pending <= gray_due.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the sRGB to gray luminance unit: clock, reset, stimulus and verdict.
module tb_top;

	typedef enum logic {SINK_RANDOM, SINK_STEADY} sink_mode_t;

	localparam int HOLD_CYCLES = 120;
	localparam int TAIL_CYCLES = 20;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] red_code;
	logic [7:0] green_code;
	logic [7:0] blue_code;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] gray_code;
	int         fail_count;
	int         pending;
	sink_mode_t sink_mode;
	logic       hold_req;
	bit         src_idle;

	srgb_to_gray_luminance_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red_code   (red_code),
		.green_code (green_code),
		.blue_code  (blue_code),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.gray_code  (gray_code)
	);

	srgb_gray_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red_code   (red_code),
		.green_code (green_code),
		.blue_code  (blue_code),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.gray_code  (gray_code),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Gray code sink: random stalls, a steady stretch, and one long hold-off on request.
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				out_ready <= 1'b0;
				hold_left = HOLD_CYCLES;
			end else if (sink_mode == SINK_STEADY) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 23);
			end
		end
	end

	// Offer one pixel beat and hold it until accepted.
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		if (src_idle) begin
			while ($urandom_range(99) < 23) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		red_code <= r;
		green_code <= g;
		blue_code <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_random(input int count);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] lvl;
		for (int n = 0; n < count; n++) begin
			r = 8'($urandom_range(255));
			g = 8'($urandom_range(255));
			b = 8'($urandom_range(255));
			case ($urandom_range(9))
				5: begin
					// dark pixels reach the linear segments of both curves
					r = 8'($urandom_range(15));
					g = 8'($urandom_range(15));
					b = 8'($urandom_range(15));
				end
				6: begin
					lvl = 8'($urandom_range(255));
					r = lvl;
					g = lvl;
					b = lvl;
				end
				7: begin
					r = $urandom_range(1) ? 8'd255 : 8'd0;
					g = $urandom_range(1) ? 8'd255 : 8'd1;
					b = $urandom_range(1) ? 8'd254 : 8'd0;
				end
				8: begin
					r = 8'($urandom_range(255, 240));
					g = 8'($urandom_range(255, 240));
					b = 8'($urandom_range(255, 240));
				end
				9: begin
					r = $urandom_range(1) ? r : 8'd0;
					g = $urandom_range(1) ? g : 8'd0;
					b = 8'd0;
				end
				default: ;
			endcase
			send_pixel(r, g, b);
		end
	endtask

	// Drop valid and wait until every gray code has come back.
	task automatic drain;
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		red_code = 8'd0;
		green_code = 8'd0;
		blue_code = 8'd0;
		hold_req = 1'b0;
		sink_mode = SINK_RANDOM;
		src_idle = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd10, 8'd10, 8'd10);
		send_pixel(8'd11, 8'd11, 8'd11);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd1, 8'd1, 8'd1);
		send_pixel(8'd2, 8'd3, 8'd4);
		send_pixel(8'd8, 8'd16, 8'd32);
		send_pixel(8'd64, 8'd128, 8'd1);
		send_pixel(8'hAA, 8'h55, 8'hAA);
		send_pixel(8'h55, 8'hAA, 8'h55);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd12, 8'd200, 8'd37);
		drain();

		// stall the sink long enough to back the pipeline up into in_ready
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		send_random(40);

		send_random(250);

		sink_mode <= SINK_STEADY;
		src_idle = 1'b0;
		send_random(150);
		sink_mode <= SINK_RANDOM;
		src_idle = 1'b1;

		send_random(180);
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/sgl_pkg.sv
hdl/sgl_linearize.sv
hdl/sgl_luma_mix.sv
hdl/sgl_encode_search.sv
hdl/srgb_to_gray_luminance_unit.sv
tb/srgb_gray_checker.sv
tb/tb_top.sv
